@@ rtl/tpd4_pkg.sv @@
// ----------------------------------------------------------------------------
// tpd4_pkg
// Shared types, codes and helpers for the 4x4-quadrant tile pattern decoder.
// ----------------------------------------------------------------------------
package tpd4_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_SECTOR = 2'd1;
  localparam logic [1:0] KIND_NEXT   = 2'd2;

  localparam logic [7:0] CTRL_RAW = 8'h01;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COUNT_LO,
    PH_CONTROLS,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DATA,
    BK_SOLID
  } bk_state_t;

  typedef enum logic [1:0] {
    JM_NONE,
    JM_RAW,
    JM_TWO
  } jmode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [9:0] tile_number;
    logic [4:0] byte_position;
    logic [7:0] pixel_pair;
    logic       dropped;
    logic       last;
  } out_item_t;

  // one accepted byte worth of writes: an optional data part, then a run of solids
  typedef struct packed {
    logic [9:0]      tile_lo;
    logic            dropped;
    jmode_t          mode;
    logic [1:0]      dq;
    logic [2:0]      didx;
    logic [7:0]      data;
    logic [3:0][7:0] ctrl;
    logic [1:0]      sq;
    logic [2:0]      scount;
  } job_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } qstat_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bstat_t;

  // quadrant base is 0/2/16/18, offsets 0,1,4,5,8,9,12,13: bits never overlap
  function automatic logic [4:0] tpd4_pos(input logic [1:0] q, input logic [2:0] i);
    tpd4_pos = {q[1], i[2:1], q[0], i[0]};
  endfunction

  function automatic logic [7:0] tpd4_two_colour(input logic [7:0] c, input logic [1:0] bits);
    logic [3:0] lft;
    logic [3:0] rgt;
    lft = bits[1] ? c[7:4] : c[3:0];
    rgt = bits[0] ? c[7:4] : c[3:0];
    tpd4_two_colour = {rgt, lft};
  endfunction

endpackage

@@ rtl/tpd4_queue.sv @@
// ----------------------------------------------------------------------------
// tpd4_queue
// Two-entry job queue between the byte parser and the write sequencer.
// ----------------------------------------------------------------------------
module tpd4_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tpd4_pkg::job_t   push_job,
  input  logic             pop,
  output tpd4_pkg::qstat_t qstat,
  output tpd4_pkg::job_t   head_job
);

  localparam int PW = $clog2(tpd4_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(tpd4_pkg::QUEUE_DEPTH + 1);

  tpd4_pkg::job_t entry_r [tpd4_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(tpd4_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(tpd4_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_job;
    end
  end

  assign qstat.full       = (cnt_r == CW'(tpd4_pkg::QUEUE_DEPTH));
  assign qstat.head_valid = (cnt_r != '0);
  assign head_job         = entry_r[rp_r];

endmodule

@@ rtl/tpd4_front.sv @@
// ----------------------------------------------------------------------------
// tpd4_front
// Byte parser: tracks sector, tile and quadrant position, keeps the quadrant
// controls and turns each accepted byte that produces writes into one job for the sequencer.
// ----------------------------------------------------------------------------
module tpd4_front #(
  parameter int TABLE_ENTRIES = tpd4_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  tpd4_pkg::in_item_t in_item,
  output logic               in_stall,
  input  tpd4_pkg::qstat_t   qstat,
  output logic               push,
  output tpd4_pkg::job_t     push_job
);

  tpd4_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [10:0] tile_r, tile_nxt;
  logic [2:0]  cs_r, cs_nxt;
  logic [1:0]  cq_r, cq_nxt;
  logic [3:0]  bs_r, bs_nxt;
  logic [7:0]  ctrl_r   [4];
  logic [7:0]  ctrl_nxt [4];

  logic        acc;
  logic        is_data;
  logic [7:0]  ctrl_w [4];
  logic        raw;
  logic [3:0]  bs_inc;
  logic        dcomplete;
  logic        ctrl_done;
  logic        run_go;
  logic [2:0]  sstart;
  logic [2:0]  scount;
  logic        run_ok;
  logic [2:0]  end_q;
  logic        finish;
  logic [15:0] rem_dec;
  logic [15:0] rem_or;

  assign in_stall = qstat.full;

  // classify the byte and find the run of solid quadrants it releases
  always_comb begin
    acc     = in_valid && !qstat.full;
    is_data = acc && (in_item.kind == tpd4_pkg::KIND_NEXT);
    for (int k = 0; k < 4; k++) begin
      ctrl_w[k] = ctrl_r[k];
    end
    if (phase_r == tpd4_pkg::PH_CONTROLS) begin
      ctrl_w[cs_r[1:0]] = in_item.data_byte;
    end
    raw       = (ctrl_r[cq_r] == tpd4_pkg::CTRL_RAW);
    bs_inc    = bs_r + 4'd1;
    dcomplete = raw ? (bs_inc >= 4'd8) : (bs_inc >= 4'd2);
    ctrl_done = (cs_r == 3'd3);
    run_go    = ((phase_r == tpd4_pkg::PH_DATA) && dcomplete) ||
                ((phase_r == tpd4_pkg::PH_CONTROLS) && ctrl_done);
    sstart    = (phase_r == tpd4_pkg::PH_CONTROLS) ? 3'd0 : ({1'b0, cq_r} + 3'd1);
    scount    = '0;
    run_ok    = 1'b1;
    for (int j = 0; j < 4; j++) begin
      if ((3'(j) >= sstart) && run_ok) begin
        if (ctrl_w[j][7:4] == ctrl_w[j][3:0]) begin
          scount = scount + 3'd1;
        end else begin
          run_ok = 1'b0;
        end
      end
    end
    end_q   = sstart + scount;
    finish  = run_go && (end_q == 3'd4);
    rem_dec = rem_r - 16'd1;
    rem_or  = rem_r | {8'h00, in_item.data_byte};
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    tile_nxt  = tile_r;
    cs_nxt    = cs_r;
    cq_nxt    = cq_r;
    bs_nxt    = bs_r;
    for (int k = 0; k < 4; k++) begin
      ctrl_nxt[k] = ctrl_r[k];
    end
    if (acc) begin
      case (in_item.kind)
        tpd4_pkg::KIND_FRAME: begin
          tile_nxt  = '0;
          rem_nxt   = '0;
          phase_nxt = tpd4_pkg::PH_IDLE;
          cs_nxt    = '0;
          cq_nxt    = '0;
          bs_nxt    = '0;
        end
        tpd4_pkg::KIND_SECTOR: begin
          rem_nxt   = {in_item.data_byte, 8'h00};
          phase_nxt = tpd4_pkg::PH_COUNT_LO;
          cs_nxt    = '0;
          cq_nxt    = '0;
          bs_nxt    = '0;
        end
        tpd4_pkg::KIND_NEXT: begin
          case (phase_r)
            tpd4_pkg::PH_COUNT_LO: begin
              rem_nxt   = rem_or;
              cs_nxt    = '0;
              phase_nxt = (rem_or == '0) ? tpd4_pkg::PH_IDLE : tpd4_pkg::PH_CONTROLS;
            end
            tpd4_pkg::PH_CONTROLS: begin
              for (int k = 0; k < 4; k++) begin
                ctrl_nxt[k] = ctrl_w[k];
              end
              cs_nxt = cs_r + 3'd1;
              if (ctrl_done) begin
                phase_nxt = tpd4_pkg::PH_DATA;
                cq_nxt    = '0;
                bs_nxt    = '0;
              end
            end
            tpd4_pkg::PH_DATA: begin
              bs_nxt = bs_inc;
            end
            default: begin
            end
          endcase
          if (run_go) begin
            if (finish) begin
              tile_nxt  = (tile_r < 11'h7FF) ? tile_r + 11'd1 : tile_r;
              rem_nxt   = rem_dec;
              cs_nxt    = '0;
              cq_nxt    = '0;
              bs_nxt    = '0;
              phase_nxt = (rem_dec == '0) ? tpd4_pkg::PH_IDLE : tpd4_pkg::PH_CONTROLS;
            end else begin
              cq_nxt    = end_q[1:0];
              bs_nxt    = '0;
              phase_nxt = tpd4_pkg::PH_DATA;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // job to the queue
  always_comb begin
    push = is_data &&
           ((phase_r == tpd4_pkg::PH_DATA) || (run_go && (scount != '0)));
    push_job.tile_lo = tile_r[9:0];
    push_job.dropped = (tile_r >= 11'(TABLE_ENTRIES));
    if (phase_r == tpd4_pkg::PH_DATA) begin
      push_job.mode = raw ? tpd4_pkg::JM_RAW : tpd4_pkg::JM_TWO;
    end else begin
      push_job.mode = tpd4_pkg::JM_NONE;
    end
    push_job.dq     = cq_r;
    push_job.didx   = raw ? bs_r[2:0] : {bs_r[0], 2'b00};
    push_job.data   = in_item.data_byte;
    for (int k = 0; k < 4; k++) begin
      push_job.ctrl[k] = ctrl_w[k];
    end
    push_job.sq     = sstart[1:0];
    push_job.scount = run_go ? scount : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tpd4_pkg::PH_IDLE;
      rem_r   <= '0;
      tile_r  <= '0;
      cs_r    <= '0;
      cq_r    <= '0;
      bs_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      tile_r  <= tile_nxt;
      cs_r    <= cs_nxt;
      cq_r    <= cq_nxt;
      bs_r    <= bs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      ctrl_r[k] <= ctrl_nxt[k];
    end
  end

endmodule

@@ rtl/tpd4_back.sv @@
// ----------------------------------------------------------------------------
// tpd4_back
// Write sequencer: walks the job at the queue head and issues one tile byte
// write per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module tpd4_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tpd4_pkg::qstat_t    qstat,
  input  tpd4_pkg::job_t      head_job,
  output tpd4_pkg::bstat_t    bstat,
  output logic                out_valid,
  input  logic                out_stall,
  output tpd4_pkg::out_item_t out_item
);

  tpd4_pkg::bk_state_t state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [1:0] quad_r, quad_nxt;
  logic [2:0] left_r, left_nxt;

  logic                out_valid_r;
  tpd4_pkg::out_item_t out_item_r;

  logic                can_adv;
  logic                data_end;
  logic                solid_end;
  logic                emit;
  logic                pop;
  logic [7:0]          shifted;
  tpd4_pkg::out_item_t item;

  assign can_adv   = !out_valid_r || !out_stall;
  assign data_end  = (head_job.mode == tpd4_pkg::JM_RAW) || (idx_r[1:0] == 2'd3);
  assign solid_end = (idx_r == 3'd7);

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    quad_nxt  = quad_r;
    left_nxt  = left_r;
    case (state_r)
      tpd4_pkg::BK_IDLE: begin
        if (qstat.head_valid) begin
          idx_nxt   = '0;
          quad_nxt  = head_job.sq;
          left_nxt  = head_job.scount;
          state_nxt = (head_job.mode != tpd4_pkg::JM_NONE) ? tpd4_pkg::BK_DATA
                                                           : tpd4_pkg::BK_SOLID;
        end
      end
      tpd4_pkg::BK_DATA: begin
        if (can_adv) begin
          if (data_end) begin
            idx_nxt   = '0;
            state_nxt = (left_r != '0) ? tpd4_pkg::BK_SOLID : tpd4_pkg::BK_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      tpd4_pkg::BK_SOLID: begin
        if (can_adv) begin
          if (solid_end) begin
            idx_nxt = '0;
            if (left_r == 3'd1) begin
              state_nxt = tpd4_pkg::BK_IDLE;
            end else begin
              quad_nxt = quad_r + 2'd1;
              left_nxt = left_r - 3'd1;
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = tpd4_pkg::BK_IDLE;
      end
    endcase
  end

  // write generation
  always_comb begin
    emit                = 1'b0;
    pop                 = 1'b0;
    shifted             = head_job.data << {idx_r[1:0], 1'b0};
    item.tile_number    = head_job.tile_lo;
    item.dropped        = head_job.dropped;
    item.byte_position  = tpd4_pkg::tpd4_pos(quad_r, idx_r);
    item.pixel_pair     = head_job.ctrl[quad_r];
    item.last           = 1'b0;
    case (state_r)
      tpd4_pkg::BK_DATA: begin
        emit = can_adv;
        if (head_job.mode == tpd4_pkg::JM_RAW) begin
          item.byte_position = tpd4_pkg::tpd4_pos(head_job.dq, head_job.didx);
          item.pixel_pair    = {head_job.data[3:0], head_job.data[7:4]};
        end else begin
          item.byte_position = tpd4_pkg::tpd4_pos(head_job.dq,
                                                  head_job.didx | {1'b0, idx_r[1:0]});
          item.pixel_pair    = tpd4_pkg::tpd4_two_colour(head_job.ctrl[head_job.dq],
                                                         shifted[7:6]);
        end
        item.last = data_end && (left_r == '0);
        pop       = emit && item.last;
      end
      tpd4_pkg::BK_SOLID: begin
        emit      = can_adv;
        item.last = solid_end && (left_r == 3'd1);
        pop       = emit && item.last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpd4_pkg::BK_IDLE;
      idx_r       <= '0;
      quad_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      quad_r  <= quad_nxt;
      left_r  <= left_nxt;
      if (can_adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= item;
    end
  end

  assign bstat.busy = (state_r != tpd4_pkg::BK_IDLE);
  assign bstat.pop  = pop;
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

endmodule

@@ rtl/tile_pattern_decode_4x4_core.sv @@
// ----------------------------------------------------------------------------
// tile_pattern_decode_4x4_core
// Byte-stream parser for the pattern section of a 4x4-quadrant tile frame,
// producing byte writes into 8x8 4-bit tiles.
// ----------------------------------------------------------------------------
// a byte's first write passes the job queue, the sequencer's idle setup state and the
// output register before it shows at out_valid; the sequencer issues one write per cycle
// while the output is not stalled, plus a setup state for each byte that produces writes;
// bytes without writes push no job and are taken whenever the job queue is not full
// a two-entry job queue decouples the parser from the sequencer
// reset: synchronous, clears parser position, tile index, queue and output valid
module tile_pattern_decode_4x4_core #(
  parameter int TABLE_ENTRIES = tpd4_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpd4_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tpd4_pkg::out_item_t out_item
);

  logic             push;
  tpd4_pkg::job_t   push_job;
  tpd4_pkg::job_t   head_job;
  tpd4_pkg::qstat_t qstat;
  tpd4_pkg::bstat_t bstat;

  tpd4_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  tpd4_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (bstat.pop),
    .qstat    (qstat),
    .head_job (head_job)
  );

  tpd4_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head_job  (head_job),
    .bstat     (bstat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("job pushed into full queue");

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.pop |-> qstat.head_valid)
    else $error("pop from empty queue");

  a_busy_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.busy |-> qstat.head_valid)
    else $error("sequencer running without a job");

  a_emit_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) && !bstat.busy |=> !out_valid)
    else $error("write issued while sequencer idle");

endmodule

@@ verif/tile_pattern_decode_4x4_core_tb.sv @@
// ----------------------------------------------------------------------------
// tile_pattern_decode_4x4_core_tb
// Feeds sector byte streams (tile counts, quadrant controls, raw, two-colour
// and solid quadrant data, plus noise and cut-short tiles) into the decoder
// and checks every tile write against a cycle-free predictor of the parser.
// A closing sector of mostly solid tiles keeps the writes coming while the
// receiver holds off.
// ----------------------------------------------------------------------------
module tile_pattern_decode_4x4_core_tb;

  // kind code with no meaning, the block drops it
  localparam logic [1:0] KIND_VOID = 2'd3;
  localparam int TILE_SLOTS = tpd4_pkg::TABLE_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 360;
  localparam logic [15:0] LONG_TILES = 16'd12;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 800000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tpd4_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tpd4_pkg::out_item_t out_item;

  tile_pattern_decode_4x4_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  tpd4_pkg::in_item_t  byte_q[$];
  tpd4_pkg::out_item_t write_q[$];

  int   in_idle_pct = 0;
  int   out_idle_pct = 0;
  bit   hold_req = 1'b0;
  bit   hold_off = 1'b0;
  logic in_took = 1'b0;

  int cycle_cnt = 0;
  int err_cnt = 0;
  int queued = 0;
  int items_taken = 0;
  int writes_checked = 0;
  int dropped_writes = 0;
  int held_stalls = 0;

  // predictor copy of the parser state
  tpd4_pkg::phase_t    ps_phase;
  logic [15:0]         ps_tiles_left;
  logic [10:0]         ps_tile;
  logic [7:0]          ps_ctl [4];
  logic [2:0]          ps_ctl_cnt;
  logic [1:0]          ps_quad;
  logic [3:0]          ps_qbytes;
  tpd4_pkg::out_item_t burst_tail;
  bit                  burst_open;

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic bit solid_ctl(input logic [7:0] c);
    return c != tpd4_pkg::CTRL_RAW && c[7:4] == c[3:0];
  endfunction

  // quadrants sit at 0, 2, 16, 18; a quadrant row is two bytes, rows 4 apart
  function automatic logic [4:0] quad_byte(input logic [1:0] q, input logic [2:0] slot);
    logic [4:0] base;
    base = (q[1] ? 5'd16 : 5'd0) + (q[0] ? 5'd2 : 5'd0);
    return base + {1'b0, slot[2:1], 2'b00} + {4'd0, slot[0]};
  endfunction

  // low nibble is the left pixel; a set bit selects the high colour
  function automatic logic [7:0] shade(input logic [7:0] ctl, input logic [1:0] sel);
    logic [3:0] lp;
    logic [3:0] rp;
    lp = sel[1] ? ctl[7:4] : ctl[3:0];
    rp = sel[0] ? ctl[7:4] : ctl[3:0];
    return {rp, lp};
  endfunction

  task automatic reset_model();
    ps_phase = tpd4_pkg::PH_IDLE;
    ps_tiles_left = '0;
    ps_tile = '0;
    for (int q = 0; q < 4; q++) ps_ctl[q] = '0;
    ps_ctl_cnt = '0;
    ps_quad = '0;
    ps_qbytes = '0;
    burst_open = 1'b0;
  endtask

  task automatic emit_write(input logic [1:0] q, input logic [2:0] slot, input logic [7:0] px);
    tpd4_pkg::out_item_t w;
    w.tile_number = ps_tile[9:0];
    w.byte_position = quad_byte(q, slot);
    w.pixel_pair = px;
    w.dropped = (ps_tile >= 11'(TILE_SLOTS));
    w.last = 1'b0;
    // hold back the newest write so the final one can be flagged
    if (burst_open) write_q.push_back(burst_tail);
    burst_tail = w;
    burst_open = 1'b1;
  endtask

  task automatic close_tile();
    if (ps_tile != 11'h7ff) ps_tile = ps_tile + 11'd1;
    ps_tiles_left = ps_tiles_left - 16'd1;
    ps_ctl_cnt = '0;
    ps_quad = '0;
    ps_qbytes = '0;
    ps_phase = (ps_tiles_left == 16'd0) ? tpd4_pkg::PH_IDLE : tpd4_pkg::PH_CONTROLS;
  endtask

  task automatic step_quad();
    ps_qbytes = '0;
    if (ps_quad == 2'd3) close_tile();
    else ps_quad = ps_quad + 2'd1;
  endtask

  task automatic flush_solids();
    logic [7:0] c;
    int i;
    while (ps_phase == tpd4_pkg::PH_DATA && solid_ctl(ps_ctl[ps_quad])) begin
      c = ps_ctl[ps_quad];
      for (i = 0; i < 8; i++) emit_write(ps_quad, i[2:0], c);
      step_quad();
    end
  endtask

  task automatic predict_writes(input tpd4_pkg::in_item_t it);
    logic [7:0] b;
    logic [7:0] c;
    int i;
    b = it.data_byte;
    burst_open = 1'b0;
    case (it.kind)
      tpd4_pkg::KIND_FRAME: begin
        ps_tile = '0;
        ps_tiles_left = '0;
        ps_phase = tpd4_pkg::PH_IDLE;
        ps_ctl_cnt = '0;
        ps_quad = '0;
        ps_qbytes = '0;
      end
      tpd4_pkg::KIND_SECTOR: begin
        ps_tiles_left = {b, 8'h00};
        ps_phase = tpd4_pkg::PH_COUNT_LO;
        ps_ctl_cnt = '0;
        ps_quad = '0;
        ps_qbytes = '0;
      end
      tpd4_pkg::KIND_NEXT: begin
        case (ps_phase)
          tpd4_pkg::PH_COUNT_LO: begin
            ps_tiles_left = ps_tiles_left | {8'h00, b};
            ps_ctl_cnt = '0;
            ps_phase = (ps_tiles_left == 16'd0) ? tpd4_pkg::PH_IDLE : tpd4_pkg::PH_CONTROLS;
          end
          tpd4_pkg::PH_CONTROLS: begin
            ps_ctl[ps_ctl_cnt[1:0]] = b;
            ps_ctl_cnt = ps_ctl_cnt + 3'd1;
            if (ps_ctl_cnt == 3'd4) begin
              ps_phase = tpd4_pkg::PH_DATA;
              ps_quad = '0;
              ps_qbytes = '0;
              flush_solids();
            end
          end
          tpd4_pkg::PH_DATA: begin
            c = ps_ctl[ps_quad];
            if (c == tpd4_pkg::CTRL_RAW) begin
              emit_write(ps_quad, ps_qbytes[2:0], {b[3:0], b[7:4]});
              ps_qbytes = ps_qbytes + 4'd1;
              if (ps_qbytes == 4'd8) step_quad();
            end else begin
              // first byte covers the top two rows, second the bottom two
              for (i = 0; i < 4; i++)
                emit_write(ps_quad, {ps_qbytes[0], i[1:0]}, shade(c, b[7 - 2 * i -: 2]));
              ps_qbytes = ps_qbytes + 4'd1;
              if (ps_qbytes == 4'd2) step_quad();
            end
            flush_solids();
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (burst_open) begin
      burst_tail.last = 1'b1;
      write_q.push_back(burst_tail);
      burst_open = 1'b0;
    end
  endtask

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic check_write(input tpd4_pkg::out_item_t got);
    tpd4_pkg::out_item_t want;
    writes_checked++;
    if (got.dropped) dropped_writes++;
    if (write_q.size() == 0) begin
      report($sformatf("unexpected write tile %0d byte %0d", got.tile_number,
                       got.byte_position));
    end else begin
      want = write_q.pop_front();
      if (got.tile_number !== want.tile_number)
        report($sformatf("tile_number %0d, want %0d", got.tile_number, want.tile_number));
      if (got.byte_position !== want.byte_position)
        report($sformatf("byte_position %0d, want %0d", got.byte_position,
                         want.byte_position));
      if (got.pixel_pair !== want.pixel_pair)
        report($sformatf("pixel_pair %h, want %h (byte %0d)", got.pixel_pair,
                         want.pixel_pair, want.byte_position));
      if (got.dropped !== want.dropped)
        report($sformatf("dropped %b, want %b", got.dropped, want.dropped));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b", got.last, want.last));
    end
  endtask

  // monitor: predicts on accepted items, checks accepted writes
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_writes(in_item);
        items_taken++;
      end
      if (hold_off && in_valid && in_stall) held_stalls++;
      if (out_valid && !out_stall) check_write(out_item);
    end
  end

  // driver: next item goes out once the current one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_item <= byte_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < out_idle_pct);
  end

  // long receiver hold-off so the job queue fills and the input backs up
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes outstanding", cycle_cnt, write_q.size());
      $display("tile_pattern_decode_4x4_core_tb: done, errors");
      $finish;
    end
  end

  task automatic put(input logic [1:0] k, input logic [7:0] b);
    tpd4_pkg::in_item_t it;
    it.kind = k;
    it.data_byte = b;
    byte_q.push_back(it);
    if (k == tpd4_pkg::KIND_SECTOR || k == tpd4_pkg::KIND_NEXT) queued++;
  endtask

  function automatic logic [7:0] pick_ctl();
    logic [7:0] r;
    r = rand_byte();
    case ($urandom_range(3))
      0: return tpd4_pkg::CTRL_RAW;
      1: return {r[3:0], r[3:0]};
      default: return r;
    endcase
  endfunction

  function automatic int data_len(input logic [7:0] c);
    if (c == tpd4_pkg::CTRL_RAW) return 8;
    else if (c[7:4] == c[3:0]) return 0;
    else return 2;
  endfunction

  // keep < 0 sends the whole tile, otherwise only its first keep bytes
  task automatic put_tile(input int keep);
    logic [7:0] ctl [4];
    int q;
    int j;
    int sent;
    sent = 0;
    for (q = 0; q < 4; q++) ctl[q] = pick_ctl();
    for (q = 0; q < 4; q++) begin
      if (keep < 0 || sent < keep) begin
        put(tpd4_pkg::KIND_NEXT, ctl[q]);
        sent++;
      end
    end
    for (q = 0; q < 4; q++) begin
      for (j = 0; j < data_len(ctl[q]); j++) begin
        if (keep < 0 || sent < keep) begin
          put(tpd4_pkg::KIND_NEXT, rand_byte());
          sent++;
        end
      end
    end
  endtask

  task automatic put_sector();
    int tiles;
    int t;
    logic [7:0] b;
    tiles = $urandom_range(4, 1);
    if ($urandom_range(7) == 0) begin
      // oversized count, cut short by whatever sector mark comes next
      b = rand_byte();
      put(tpd4_pkg::KIND_SECTOR, b | 8'h01);
      put(tpd4_pkg::KIND_NEXT, rand_byte());
    end else begin
      put(tpd4_pkg::KIND_SECTOR, 8'h00);
      put(tpd4_pkg::KIND_NEXT, tiles[7:0]);
    end
    for (t = 0; t < tiles; t++) begin
      if ($urandom_range(11) == 0) begin
        put_tile($urandom_range(11));
        return;
      end
      put_tile(-1);
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) put(tpd4_pkg::KIND_NEXT, rand_byte());
    end
  endtask

  task automatic put_random(input int goal);
    int start;
    logic [31:0] r;
    start = queued;
    while (queued - start < goal) begin
      r = $urandom;
      case ($urandom_range(15))
        0: put(tpd4_pkg::KIND_FRAME, r[7:0]);
        1: put(KIND_VOID, r[7:0]);
        2: put(r[9:8], r[7:0]);
        default: put_sector();
      endcase
    end
  endtask

  task automatic put_directed();
    put(tpd4_pkg::KIND_FRAME, 8'hff);
    put(tpd4_pkg::KIND_NEXT, 8'h5a);      // idle, ignored
    put(KIND_VOID, 8'hff);
    put(tpd4_pkg::KIND_SECTOR, 8'h00);    // zero tile count
    put(tpd4_pkg::KIND_NEXT, 8'h00);
    put(tpd4_pkg::KIND_SECTOR, 8'h00);
    put(tpd4_pkg::KIND_NEXT, 8'h02);
    put(tpd4_pkg::KIND_NEXT, tpd4_pkg::CTRL_RAW);
    put(tpd4_pkg::KIND_NEXT, 8'hf0);      // two colour
    put(tpd4_pkg::KIND_NEXT, 8'hff);      // solid, released by the last two-colour byte
    put(tpd4_pkg::KIND_NEXT, 8'h0f);
    put(tpd4_pkg::KIND_NEXT, 8'h00);
    put(tpd4_pkg::KIND_NEXT, 8'hff);
    put(tpd4_pkg::KIND_NEXT, 8'h0f);
    put(tpd4_pkg::KIND_NEXT, 8'hf0);
    put(tpd4_pkg::KIND_NEXT, 8'h12);
    put(tpd4_pkg::KIND_NEXT, 8'h80);
    put(tpd4_pkg::KIND_NEXT, 8'h01);
    put(tpd4_pkg::KIND_NEXT, 8'h7e);
    put(tpd4_pkg::KIND_NEXT, 8'h00);
    put(tpd4_pkg::KIND_NEXT, 8'hff);
    put(tpd4_pkg::KIND_NEXT, 8'ha5);
    put(tpd4_pkg::KIND_NEXT, 8'h3c);
    put(tpd4_pkg::KIND_NEXT, 8'h00);      // second tile abandoned after two controls
    put(tpd4_pkg::KIND_NEXT, 8'h11);
    put(tpd4_pkg::KIND_SECTOR, 8'h00);
  endtask

  // mostly solid tiles: four bytes in, a full tile of writes out
  task automatic put_long_sector();
    int t;
    int q;
    logic [7:0] b;
    put(tpd4_pkg::KIND_FRAME, 8'h00);
    put(tpd4_pkg::KIND_SECTOR, LONG_TILES[15:8]);
    put(tpd4_pkg::KIND_NEXT, LONG_TILES[7:0]);
    for (t = 0; t < LONG_TILES; t++) begin
      if ($urandom_range(15) == 0) begin
        put_tile(-1);
      end else begin
        for (q = 0; q < 4; q++) begin
          b = rand_byte();
          put(tpd4_pkg::KIND_NEXT, {b[3:0], b[3:0]});
        end
      end
    end
  endtask

  task automatic wait_sent();
    while (byte_q.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 37;
    out_idle_pct = 65;
    put_directed();
    put_random(RANDOM_ITEMS / 3);
    wait_sent();
    in_idle_pct = 65;
    out_idle_pct = 37;
    put_random(RANDOM_ITEMS / 3);
    wait_sent();
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_req = 1'b1;
    put_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    put_long_sector();
    wait_sent();
    while (write_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d items and %0d checked writes, %0d of them past the table",
             items_taken, writes_checked, dropped_writes);
    $display("input held back for %0d cycles during the output hold-off, %0d mismatches",
             held_stalls, err_cnt);
    if (err_cnt == 0) $display("tile_pattern_decode_4x4_core_tb: done, clean");
    else $display("tile_pattern_decode_4x4_core_tb: done, errors");
    $finish;
  end

endmodule
